@@ hdl/ed_pkg.sv @@
// Shared types, constants and codes for the entropy/decisiveness block.
`timescale 1ns / 1ps

package ed_pkg;

   localparam int FRAC_BITS    = 16;   // fraction bits of the log2 estimate
   localparam int MAX_ELEMENTS = 256;  // intended distribution length, not enforced
   localparam int PROB_W       = 17;
   localparam int X_W          = 16;
   localparam int EXP_W        = 4;
   localparam int MANT_W       = 31;   // Q1.30 mantissa
   localparam int PROD_W       = 2 * MANT_W;
   localparam int NEG_LOG_W    = FRAC_BITS + 5;
   localparam int TERM_W       = 21;
   localparam int ACC_W        = 24;
   localparam int DEN_W        = 25;
   localparam int QUOT_W       = 17;
   localparam int CNT_W        = 5;
   localparam int DIV_STEPS    = QUOT_W;

   localparam logic [CNT_W-1:0] SQ_LAST  = CNT_W'(FRAC_BITS - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
   localparam logic [ACC_W-1:0] ACC_MAX  = {ACC_W{1'b1}};
   localparam logic [DEN_W-1:0] ONE_Q16  = DEN_W'(65536);
   localparam logic [QUOT_W-1:0] DEC_MAX = QUOT_W'(65536);

   typedef struct packed {
      logic [PROB_W-1:0] prob;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [ACC_W-1:0]  entropy;
      logic [QUOT_W-1:0] decisiveness;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQUARE,
      OP_TERM,
      OP_ACC,
      OP_DIVINIT,
      OP_DIVSTEP,
      OP_OUT
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SQUARE,
      S_TERM,
      S_ACC,
      S_DIVINIT,
      S_DIV,
      S_OUT
   } state_type;

   typedef struct packed {
      op_type op;
      logic   out_load;
   } ctrl_type;

   typedef struct packed {
      logic skip;
      logic last;
   } status_type;

endpackage

@@ hdl/ed_datapath.sv @@
// Shared multiply / subtract datapath: log2 squaring, term, accumulate, divide.
`timescale 1ns / 1ps

module ed_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  ed_pkg::ctrl_type               ctrl,
   input  ed_pkg::req_type                req_data,
   output ed_pkg::status_type             status,
   output logic [ed_pkg::ACC_W-1:0]       entropy,
   output logic [ed_pkg::QUOT_W-1:0]      decisiveness
);

   logic [ed_pkg::X_W-1:0]       x_ff, x_in;
   logic [ed_pkg::EXP_W-1:0]     e_ff, e_in;
   logic [ed_pkg::MANT_W-1:0]    m_ff, m_in;
   logic [ed_pkg::FRAC_BITS-1:0] frac_ff, frac_in;
   logic                         skip_ff, skip_in;
   logic                         last_ff, last_in;
   logic [ed_pkg::TERM_W-1:0]    term_ff, term_in;
   logic [ed_pkg::ACC_W-1:0]     acc_ff, acc_in;
   logic [ed_pkg::DEN_W-1:0]     d_ff, d_in;
   logic [ed_pkg::DEN_W-1:0]     rem_ff, rem_in;
   logic [ed_pkg::QUOT_W-1:0]    numlo_ff, numlo_in;
   logic [ed_pkg::QUOT_W-1:0]    q_ff, q_in;

   logic [ed_pkg::MANT_W-1:0]    mul_a, mul_b;
   logic [ed_pkg::PROD_W-1:0]    prod;
   logic [ed_pkg::EXP_W-1:0]     msb;
   logic [4:0]                   shamt;
   logic [45:0]                  norm;
   logic [ed_pkg::NEG_LOG_W-1:0] neg_log;
   logic [ed_pkg::ACC_W:0]       sum;
   logic [ed_pkg::DEN_W-1:0]     d_now;
   logic [32:0]                  numer;
   logic [ed_pkg::DEN_W:0]       trial;
   logic [ed_pkg::DEN_W+1:0]     diff;

   // leading-one position of the 16-bit probability
   always_comb begin
      msb = '0;
      for (int i = 0; i < ed_pkg::X_W; i++) begin
         if (req_data.prob[i]) begin
            msb = ed_pkg::EXP_W'(i);
         end
      end
      shamt = 5'd30 - 5'(msb);
      norm  = {30'd0, req_data.prob[ed_pkg::X_W-1:0]} << shamt;
   end

   // -log2(p) = 16 - log2(x), Q.FRAC_BITS
   assign neg_log = ed_pkg::NEG_LOG_W'(16 << ed_pkg::FRAC_BITS)
                  - ed_pkg::NEG_LOG_W'({e_ff, frac_ff});

   // the one multiplier, shared by squaring and term
   always_comb begin
      case (ctrl.op)
         ed_pkg::OP_SQUARE: begin
            mul_a = m_ff;
            mul_b = m_ff;
         end
         ed_pkg::OP_TERM: begin
            mul_a = ed_pkg::MANT_W'(x_ff);
            mul_b = ed_pkg::MANT_W'(neg_log);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod = mul_a * mul_b;

   assign sum   = {1'b0, acc_ff} + (ed_pkg::ACC_W+1)'(term_ff);
   assign d_now = ed_pkg::ONE_Q16 + ed_pkg::DEN_W'(acc_ff);
   assign numer = {1'b1, 32'd0} + 33'(d_now >> 1);
   assign trial = {rem_ff, numlo_ff[ed_pkg::QUOT_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, d_ff};

   always_comb begin
      x_in     = x_ff;
      e_in     = e_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      skip_in  = skip_ff;
      last_in  = last_ff;
      term_in  = term_ff;
      acc_in   = acc_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      numlo_in = numlo_ff;
      q_in     = q_ff;
      case (ctrl.op)
         ed_pkg::OP_LOAD: begin
            x_in    = req_data.prob[ed_pkg::X_W-1:0];
            e_in    = msb;
            m_in    = norm[ed_pkg::MANT_W-1:0];
            frac_in = '0;
            // zero and one-or-above carry no information
            skip_in = (req_data.prob == '0) || req_data.prob[ed_pkg::PROB_W-1];
            last_in = req_data.last;
         end
         ed_pkg::OP_SQUARE: begin
            if (prod[ed_pkg::PROD_W-1]) begin
               m_in    = prod[ed_pkg::PROD_W-1:31];
               frac_in = {frac_ff[ed_pkg::FRAC_BITS-2:0], 1'b1};
            end else begin
               m_in    = prod[60:30];
               frac_in = {frac_ff[ed_pkg::FRAC_BITS-2:0], 1'b0};
            end
         end
         ed_pkg::OP_TERM: begin
            term_in = prod[ed_pkg::FRAC_BITS+ed_pkg::TERM_W-1:ed_pkg::FRAC_BITS];
         end
         ed_pkg::OP_ACC: begin
            acc_in = sum[ed_pkg::ACC_W] ? ed_pkg::ACC_MAX : sum[ed_pkg::ACC_W-1:0];
         end
         ed_pkg::OP_DIVINIT: begin
            d_in     = d_now;
            rem_in   = ed_pkg::DEN_W'(numer[32:17]);
            numlo_in = numer[16:0];
            q_in     = '0;
         end
         ed_pkg::OP_DIVSTEP: begin
            numlo_in = {numlo_ff[ed_pkg::QUOT_W-2:0], 1'b0};
            if (!diff[ed_pkg::DEN_W+1]) begin
               rem_in = diff[ed_pkg::DEN_W-1:0];
               q_in   = {q_ff[ed_pkg::QUOT_W-2:0], 1'b1};
            end else begin
               rem_in = trial[ed_pkg::DEN_W-1:0];
               q_in   = {q_ff[ed_pkg::QUOT_W-2:0], 1'b0};
            end
         end
         ed_pkg::OP_OUT: begin
            acc_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      e_ff     <= e_in;
      m_ff     <= m_in;
      frac_ff  <= frac_in;
      skip_ff  <= skip_in;
      last_ff  <= last_in;
      term_ff  <= term_in;
      d_ff     <= d_in;
      rem_ff   <= rem_in;
      numlo_ff <= numlo_in;
      q_ff     <= q_in;
   end

   assign status.skip   = skip_ff;
   assign status.last   = last_ff;
   assign entropy       = acc_ff;
   assign decisiveness  = q_ff;

   a_mant_norm: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == ed_pkg::OP_SQUARE |-> m_ff[ed_pkg::MANT_W-1])
      else $error("log2 mantissa left [1,2)");

   a_rem_below_d: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == ed_pkg::OP_DIVSTEP |-> rem_ff < d_ff)
      else $error("divider remainder not below divisor");

   a_dec_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == ed_pkg::OP_OUT |-> q_ff <= ed_pkg::DEC_MAX)
      else $error("decisiveness above 1.0");

endmodule

@@ hdl/ed_ctrl.sv @@
// Sequencer that steps the shared datapath through each element, the final divide and the result load.
`timescale 1ns / 1ps

module ed_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ed_pkg::status_type status,
   input  logic               out_free,
   output ed_pkg::ctrl_type   ctrl
);

   ed_pkg::state_type           state_ff, state_in;
   logic [ed_pkg::CNT_W-1:0]    cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ed_pkg::S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ctrl.op       = ed_pkg::OP_NONE;
      ctrl.out_load = 1'b0;
      req_stall     = 1'b1;
      case (state_ff)
         ed_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.op  = ed_pkg::OP_LOAD;
               state_in = ed_pkg::S_CHECK;
            end
         end
         ed_pkg::S_CHECK: begin
            cnt_in = '0;
            if (!status.skip) begin
               state_in = ed_pkg::S_SQUARE;
            end else if (status.last) begin
               state_in = ed_pkg::S_DIVINIT;
            end else begin
               state_in = ed_pkg::S_IDLE;
            end
         end
         ed_pkg::S_SQUARE: begin
            ctrl.op = ed_pkg::OP_SQUARE;
            if (cnt_ff == ed_pkg::SQ_LAST) begin
               cnt_in   = '0;
               state_in = ed_pkg::S_TERM;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ed_pkg::S_TERM: begin
            ctrl.op  = ed_pkg::OP_TERM;
            state_in = ed_pkg::S_ACC;
         end
         ed_pkg::S_ACC: begin
            ctrl.op  = ed_pkg::OP_ACC;
            state_in = status.last ? ed_pkg::S_DIVINIT : ed_pkg::S_IDLE;
         end
         ed_pkg::S_DIVINIT: begin
            ctrl.op  = ed_pkg::OP_DIVINIT;
            cnt_in   = '0;
            state_in = ed_pkg::S_DIV;
         end
         ed_pkg::S_DIV: begin
            ctrl.op = ed_pkg::OP_DIVSTEP;
            if (cnt_ff == ed_pkg::DIV_LAST) begin
               cnt_in   = '0;
               state_in = ed_pkg::S_OUT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ed_pkg::S_OUT: begin
            if (out_free) begin
               ctrl.op       = ed_pkg::OP_OUT;
               ctrl.out_load = 1'b1;
               state_in      = ed_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ed_pkg::S_IDLE;
         end
      endcase
   end

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ed_pkg::S_CHECK)
      else $error("beat accepted but sequencer did not start");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.out_load |-> out_free)
      else $error("result loaded over an untaken one");

   a_sq_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ed_pkg::S_SQUARE |-> cnt_ff <= ed_pkg::SQ_LAST)
      else $error("squaring count overran");

endmodule

@@ hdl/entropy_decisiveness.sv @@
// Top level: streamed base-2 entropy with decisiveness 1/(1+H).
// Sequence: an element that carries information goes from accept to the next
//    accept through load, check, 16 squarings of the log2 loop, term and add.
// Elements equal to 0 or >= 1.0 go through load and check only. A last element
//    adds divide setup, a restoring divide and a result load that waits for out_free.
// Reset (synchronous, active high) clears the sequencer, the entropy
//    accumulator and the result register valid; no memory to sweep.
`timescale 1ns / 1ps

module entropy_decisiveness (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ed_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output ed_pkg::rsp_type rsp_data
);

   ed_pkg::ctrl_type               ctrl;
   ed_pkg::status_type             status;
   logic [ed_pkg::ACC_W-1:0]       entropy;
   logic [ed_pkg::QUOT_W-1:0]      decisiveness;
   logic                           out_free;

   logic            rsp_valid_ff, rsp_valid_in;
   ed_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Sequencer: one element at a time, stalls the request side while busy.
   ed_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .out_free  (out_free),
      .ctrl      (ctrl)
   );

   // Shared multiplier/subtractor datapath holding the accumulator.
   ed_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .req_data     (req_data),
      .status       (status),
      .entropy      (entropy),
      .decisiveness (decisiveness)
   );

   // Result register: free when empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.out_load) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.entropy       = entropy;
         rsp_data_in.decisiveness  = decisiveness;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
